// ===== rtl/smtf_pkg.sv =====
`default_nettype none

package smtf_pkg;

   // window and log geometry
   localparam int MEDIAN_DEPTH = 5;
   localparam int LOG_DEPTH    = 8;
   localparam int MED_IDX      = MEDIAN_DEPTH / 2;

   localparam int WP_W   = $clog2(MEDIAN_DEPTH);
   localparam int LP_W   = $clog2(LOG_DEPTH);
   localparam int RANK_W = $clog2(MEDIAN_DEPTH + 1);

   // field widths
   localparam int ECHO_W = 16;
   localparam int DIST_W = 15;
   localparam int DIFF_W = DIST_W + 1;

   // echo time to q.4 cm: (t * 1114) >> 12
   localparam int DIST_MUL   = 1114;
   localparam int MUL_W      = 11;
   localparam int DIST_SHIFT = 12;
   localparam int PROD_W     = ECHO_W + MUL_W;

   localparam logic [DIST_W-1:0] MAX_DIST_RESET = DIST_W'(6400);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_LOAD,
      ST_RANK,
      ST_SCAN,
      ST_LIMIT,
      ST_TREND
   } state_type;

   typedef struct packed {
      logic                     lt;
      logic                     eq;
      logic signed [DIFF_W-1:0] diff;
   } cmp_res_type;

endpackage

`default_nettype wire

// ===== rtl/smtf_cmp.sv =====
`default_nettype none

module smtf_cmp
   import smtf_pkg::*;
(
   input  wire logic [DIST_W-1:0] op_a,
   input  wire logic [DIST_W-1:0] op_b,
   output cmp_res_type            res
);

   // shared compare/subtract unit, a against b
   always_comb begin
      res.lt   = (op_a < op_b);
      res.eq   = (op_a == op_b);
      res.diff = $signed({1'b0, op_a}) - $signed({1'b0, op_b});
   end

endmodule

`default_nettype wire

// ===== rtl/sonar_median_trend_filter.sv =====
// timing: request accept to result valid is set by the rank search
//   (1 to 5 candidates, each loaded then ranked against the window) plus the log scan,
//   and is longer while the previous result still waits on rsp_tready
// takes no new request until the result is registered; distance compares share one unit
// reset: synchronous active-high reset clears the window, the log, both
//   pointers, the state machine and the output valid; max_distance returns to 6400
`default_nettype none

module sonar_median_trend_filter
   import smtf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [15:0]       req_tdata,   // [15:0] echo_time_us
   // result channel
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [31:0]            rsp_tdata,   // [14:0] distance_q4, [15] rising,
                                               // [16] falling, [31:17] rise_rate
   // configuration
   input  wire logic              csr_wr_en,
   input  wire logic [DIST_W-1:0] csr_wr_data  // max_distance
);

   localparam logic signed [DIFF_W-1:0] LOG_DEPTH_S = DIFF_W'(LOG_DEPTH);
   localparam logic [WP_W-1:0]          WIN_LAST    = WP_W'(MEDIAN_DEPTH - 1);
   localparam logic [LP_W-1:0]          LOG_LAST    = LP_W'(LOG_DEPTH - 1);

   // sequencer state
   state_type state_ff, state_in;

   // storage: sliding window and median history log
   logic [DIST_W-1:0] window_ff [MEDIAN_DEPTH];
   logic [DIST_W-1:0] log_ff    [LOG_DEPTH];
   logic              win_we;
   logic              log_we;

   logic [DIST_W-1:0] max_dist_ff;

   // control registers
   logic [WP_W-1:0]   wptr_ff, wptr_in;
   logic [LP_W-1:0]   lptr_ff, lptr_in;
   logic [WP_W-1:0]   cand_idx_ff, cand_idx_in;
   logic [WP_W-1:0]   scan_j_ff, scan_j_in;
   logic [RANK_W-1:0] rank_ff, rank_in;
   logic [LP_W-1:0]   log_k_ff, log_k_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [ECHO_W-1:0] echo_ff, echo_in;
   logic [DIST_W-1:0] cand_ff, cand_in;
   logic [DIST_W-1:0] med_ff, med_in;
   logic [DIST_W-1:0] oldest_ff, oldest_in;
   logic [DIST_W-1:0] prev_ff, prev_in;
   logic              rising_ff, rising_in;
   logic [DIST_W-1:0] dist_out_ff, dist_out_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;

   // datapath
   logic [PROD_W-1:0]   product;
   logic [DIST_W-1:0]   dist_new;
   logic [WP_W-1:0]     win_addr;
   logic [DIST_W-1:0]   win_rd;
   logic [LP_W:0]       log_sum;
   logic [LP_W-1:0]     log_addr;
   logic [DIST_W-1:0]   log_rd;
   logic [DIST_W-1:0]   cmp_a;
   logic [DIST_W-1:0]   cmp_b;
   cmp_res_type         cmp_res;
   logic [RANK_W-1:0]   rank_next;
   logic signed [DIFF_W-1:0] rate_full;
   logic                rsp_free;

   // echo time to q.4 distance, one multiply
   assign product  = PROD_W'(echo_ff) * PROD_W'(DIST_MUL);
   assign dist_new = product[DIST_SHIFT +: DIST_W];

   // single read port on the window: candidate load or rank sweep
   assign win_addr = (state_ff == ST_LOAD) ? cand_idx_ff : scan_j_ff;
   assign win_rd   = window_ff[win_addr];

   // log read walks from the oldest entry
   assign log_sum  = {1'b0, lptr_ff} + {1'b0, log_k_ff};
   assign log_addr = (log_sum >= (LP_W+1)'(LOG_DEPTH)) ?
                     LP_W'(log_sum - (LP_W+1)'(LOG_DEPTH)) : log_sum[LP_W-1:0];
   assign log_rd   = log_ff[log_addr];

   // operand select for the shared compare unit
   always_comb begin
      case (state_ff)
         ST_RANK: begin
            cmp_a = win_rd;
            cmp_b = cand_ff;
         end
         ST_SCAN: begin
            cmp_a = prev_ff;
            cmp_b = log_rd;
         end
         ST_LIMIT: begin
            cmp_a = med_ff;
            cmp_b = max_dist_ff;
         end
         ST_TREND: begin
            cmp_a = med_ff;
            cmp_b = oldest_ff;
         end
         default: begin
            cmp_a = med_ff;
            cmp_b = oldest_ff;
         end
      endcase
   end

   smtf_cmp u_cmp (
      .op_a (cmp_a),
      .op_b (cmp_b),
      .res  (cmp_res)
   );

   // stable rank: smaller values, plus equal values at lower slots
   assign rank_next = rank_ff + RANK_W'(cmp_res.lt ||
                                        (cmp_res.eq && (scan_j_ff < cand_idx_ff)));

   // signed division truncates toward zero
   assign rate_full = cmp_res.diff / LOG_DEPTH_S;

   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   // next state and datapath control
   always_comb begin
      state_in     = state_ff;
      wptr_in      = wptr_ff;
      lptr_in      = lptr_ff;
      cand_idx_in  = cand_idx_ff;
      scan_j_in    = scan_j_ff;
      rank_in      = rank_ff;
      log_k_in     = log_k_ff;
      rsp_valid_in = rsp_valid_ff;
      echo_in      = echo_ff;
      cand_in      = cand_ff;
      med_in       = med_ff;
      oldest_in    = oldest_ff;
      prev_in      = prev_ff;
      rising_in    = rising_ff;
      dist_out_in  = dist_out_ff;
      rsp_data_in  = rsp_data_ff;
      win_we       = 1'b0;
      log_we       = 1'b0;
      req_tready   = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               echo_in  = req_tdata[ECHO_W-1:0];
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            // replace oldest window slot
            win_we      = 1'b1;
            wptr_in     = (wptr_ff == WIN_LAST) ? '0 : wptr_ff + WP_W'(1);
            cand_idx_in = '0;
            state_in    = ST_LOAD;
         end
         ST_LOAD: begin
            cand_in   = win_rd;
            scan_j_in = '0;
            rank_in   = '0;
            state_in  = ST_RANK;
         end
         ST_RANK: begin
            rank_in = rank_next;
            if (scan_j_ff == WIN_LAST) begin
               if (rank_next == RANK_W'(MED_IDX)) begin
                  // median found, append to log
                  med_in   = cand_ff;
                  log_we   = 1'b1;
                  lptr_in  = (lptr_ff == LOG_LAST) ? '0 : lptr_ff + LP_W'(1);
                  log_k_in = '0;
                  state_in = ST_SCAN;
               end else begin
                  cand_idx_in = cand_idx_ff + WP_W'(1);
                  state_in    = ST_LOAD;
               end
            end else begin
               scan_j_in = scan_j_ff + WP_W'(1);
            end
         end
         ST_SCAN: begin
            prev_in = log_rd;
            if (log_k_ff == '0) begin
               oldest_in = log_rd;
               rising_in = 1'b1;
            end else if (!cmp_res.lt) begin
               rising_in = 1'b0;
            end
            if (log_k_ff == LOG_LAST) begin
               state_in = ST_LIMIT;
            end else begin
               log_k_in = log_k_ff + LP_W'(1);
            end
         end
         ST_LIMIT: begin
            dist_out_in = cmp_res.lt ? med_ff : '0;
            state_in    = ST_TREND;
         end
         ST_TREND: begin
            // hold here until the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {rate_full[DIST_W-1:0], cmp_res.lt, rising_ff, dist_out_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wptr_ff      <= '0;
         lptr_ff      <= '0;
         cand_idx_ff  <= '0;
         scan_j_ff    <= '0;
         rank_ff      <= '0;
         log_k_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         max_dist_ff  <= MAX_DIST_RESET;
      end else begin
         state_ff     <= state_in;
         wptr_ff      <= wptr_in;
         lptr_ff      <= lptr_in;
         cand_idx_ff  <= cand_idx_in;
         scan_j_ff    <= scan_j_in;
         rank_ff      <= rank_in;
         log_k_ff     <= log_k_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_dist_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      echo_ff     <= echo_in;
      cand_ff     <= cand_in;
      med_ff      <= med_in;
      oldest_ff   <= oldest_in;
      prev_ff     <= prev_in;
      rising_ff   <= rising_in;
      dist_out_ff <= dist_out_in;
      rsp_data_ff <= rsp_data_in;
   end

   // window and log, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MEDIAN_DEPTH; i++) begin
            window_ff[i] <= '0;
         end
         for (int i = 0; i < LOG_DEPTH; i++) begin
            log_ff[i] <= '0;
         end
      end else begin
         if (win_we) begin
            window_ff[wptr_ff] <= dist_new;
         end
         if (log_we) begin
            log_ff[lptr_ff] <= cand_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // busy right after a request is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

   // a median must be found before the candidate list runs out
   a_rank_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RANK) |-> (rank_ff < RANK_W'(MEDIAN_DEPTH)))
      else $error("rank count overflow");

   a_cand_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (cand_idx_ff <= WIN_LAST))
      else $error("no median candidate left");

   // pointers stay inside their stores
   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      (wptr_ff <= WIN_LAST) && (lptr_ff <= LOG_LAST))
      else $error("ring pointer out of range");

   // a result is only produced when the output register was free
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TREND && !rsp_free) |=> (state_ff == ST_TREND))
      else $error("result dropped while output busy");

endmodule

`default_nettype wire

// ===== verif/sonar_median_trend_filter_tb.sv =====
`default_nettype none

module sonar_median_trend_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import smtf_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int SETTLE_CYCLES = 60;   // above the worst-case block latency
   localparam int QUIET_LIMIT = 2000;   // cycles with no handshake before giving up

   // one expected result, fields in the order they sit in rsp_tdata
   typedef struct packed {
      logic [DIST_W-1:0] rise_rate;
      logic              falling;
      logic              rising;
      logic [DIST_W-1:0] distance_q4;
   } reading_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [15:0]       req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;
   logic              csr_wr_en = 1'b0;
   logic [DIST_W-1:0] csr_wr_data = '0;

   // stimulus and scoreboard
   logic [ECHO_W-1:0] echo_q[$];
   reading_type       expected_readings[$];
   logic              req_fire = 1'b0;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   int                mismatches = 0;
   int                requests_sent = 0;
   int                results_checked = 0;
   int                limits_used = 0;
   int                quiet_cycles = 0;

   // shadow copy of the filter state
   logic [DIST_W-1:0] win [MEDIAN_DEPTH];
   logic [DIST_W-1:0] hist [LOG_DEPTH];
   int                win_ptr;
   int                log_ptr;
   logic [DIST_W-1:0] max_dist;

   sonar_median_trend_filter DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // convert, push into the window, take the median, log it and read the trend
   function automatic reading_type predict_reading(input logic [ECHO_W-1:0] echo);
      logic [31:0]       prod;
      logic [DIST_W-1:0] conv_dist;
      logic [DIST_W-1:0] med;
      logic [DIST_W-1:0] oldest;
      logic [DIST_W-1:0] prev;
      logic [DIST_W-1:0] cur;
      logic [DIST_W-1:0] swap;
      logic [DIST_W-1:0] sorted [MEDIAN_DEPTH];
      logic              rise;
      int                diff;
      reading_type       r;
      prod = 32'(echo) * 32'(DIST_MUL);
      conv_dist = DIST_W'(prod >> DIST_SHIFT);
      win[win_ptr] = conv_dist;
      win_ptr = (win_ptr + 1) % MEDIAN_DEPTH;
      // the window keeps ring order, so sort a copy
      sorted = win;
      for (int i = 0; i < MEDIAN_DEPTH - 1; i++) begin
         for (int j = 0; j < MEDIAN_DEPTH - 1 - i; j++) begin
            if (sorted[j] > sorted[j+1]) begin
               swap = sorted[j];
               sorted[j] = sorted[j+1];
               sorted[j+1] = swap;
            end
         end
      end
      med = sorted[MEDIAN_DEPTH / 2];
      // raw median goes into the log, even when it is reported as zero
      hist[log_ptr] = med;
      log_ptr = (log_ptr + 1) % LOG_DEPTH;
      // after the write the pointer sits on the oldest entry
      oldest = hist[log_ptr];
      prev = oldest;
      rise = 1'b1;
      for (int k = 1; k < LOG_DEPTH; k++) begin
         cur = hist[(log_ptr + k) % LOG_DEPTH];
         if (cur <= prev) rise = 1'b0;
         prev = cur;
      end
      // int division truncates toward zero
      diff = (int'(med) - int'(oldest)) / LOG_DEPTH;
      r.distance_q4 = (med < max_dist) ? med : '0;
      r.rising = rise;
      r.falling = (med < oldest);
      r.rise_rate = DIST_W'(diff);
      return r;
   endfunction

   // monitor: register writes, accepted requests and arriving results
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MEDIAN_DEPTH; i++) win[i] = '0;
         for (int i = 0; i < LOG_DEPTH; i++) hist[i] = '0;
         win_ptr = 0;
         log_ptr = 0;
         max_dist = MAX_DIST_RESET;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_readings.size() == 0) begin
               mismatches++;
               $display("%0t: result 0x%h arrived with no request waiting", $time, rsp_tdata);
            end else begin
               reading_type want;
               reading_type got;
               want = expected_readings.pop_front();
               got = rsp_tdata;
               results_checked++;
               if (got !== want) begin
                  mismatches++;
                  $display("%0t: expected dist %0d rise %0b fall %0b rate %0d, got %0d %0b %0b %0d",
                     $time, want.distance_q4, want.rising, want.falling,
                     $signed(want.rise_rate), got.distance_q4, got.rising,
                     got.falling, $signed(got.rise_rate));
               end
            end
         end
         if (csr_wr_en) max_dist = csr_wr_data;
         if (req_tvalid && req_tready) begin
            expected_readings.push_back(predict_reading(req_tdata));
            requests_sent++;
         end
      end
      req_fire <= !reset && req_tvalid && req_tready;
   end

   // driver: inputs move on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         // hold a request until it has been taken
         if (!req_tvalid || req_fire) begin
            if (echo_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= echo_q.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   // sender pauses until every queued request has been answered
   // checked on the rising edge, once the driver's updates have settled
   task automatic wait_idle();
      @(posedge clock);
      while (echo_q.size() != 0 || req_tvalid || expected_readings.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   // new distance limit, only with the block idle
   task automatic write_limit(input logic [DIST_W-1:0] value);
      wait_idle();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      limits_used++;
   endtask

   // mostly approach, retreat and steady runs, some spikes and noise
   task automatic add_segments(input int count);
      int kind;
      int len;
      int base;
      int step;
      int v;
      while (count > 0) begin
         kind = $urandom_range(0, 9);
         len = $urandom_range(6, 20);
         if (len > count) len = count;
         base = $urandom_range(0, 65535);
         step = $urandom_range(4, 1500);
         for (int i = 0; i < len; i++) begin
            case (kind)
               0, 1, 2: v = base / 2 + step * i;   // retreat, step of 4 us moves a count
               3, 4, 5: v = base - step * i;       // approach
               6, 7:    v = base + int'($urandom_range(0, 40)) - 20;   // steady with jitter
               8:       v = (i % 4 == 3) ? int'($urandom_range(0, 65535)) : base;   // spikes
               default: v = int'($urandom_range(0, 65535));   // noise
            endcase
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;   // inputs arrive saturated
            echo_q.push_back(ECHO_W'(v));
         end
         count -= len;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver heavily
      send_idle_pct = 17;
      recv_idle_pct = 78;

      // directed: start-up zeros, full-scale echoes, return to zero
      echo_q.push_back(16'h0000);
      repeat (3) echo_q.push_back(16'hFFFF);   // median at the conversion maximum, over limit
      repeat (3) echo_q.push_back(16'h0000);   // median drops back to zero
      echo_q.push_back(16'h5555);
      echo_q.push_back(16'hAAAA);
      // steady retreat long enough for a strictly rising log
      for (int i = 0; i < 12; i++) echo_q.push_back(ECHO_W'(2000 + 1500 * i));
      wait_idle();

      // limit of zero blanks every distance
      write_limit('0);
      add_segments(60);
      // widest limit
      write_limit({DIST_W{1'b1}});
      add_segments(150);
      wait_idle();
      add_segments(150);

      // receiver idles lightly, sender heavily
      write_limit(DIST_W'($urandom_range(1, 32766)));
      send_idle_pct = 78;
      recv_idle_pct = 17;
      add_segments(250);
      write_limit(DIST_W'(1));
      add_segments(100);
      write_limit(DIST_W'(3000));
      add_segments(250);

      // back to back on both sides
      write_limit(MAX_DIST_RESET);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_segments(200);
      write_limit(DIST_W'($urandom_range(0, 32767)));
      add_segments(200);

      wait_idle();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("covered %0d requests, %0d results checked, %0d limit settings",
         requests_sent, results_checked, limits_used);
      $display("pacing went sender-light, receiver-light, then back to back");
      if (mismatches == 0 && expected_readings.size() == 0) begin
         $display("All tests passed");
      end else begin
         if (expected_readings.size() != 0)
            $display("%0t: %0d results never arrived", $time, expected_readings.size());
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
